[hdl/assert_macros.svh]
// Assertion macros used by the verification checker of the record table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/krt_pkg.sv]
`timescale 1ns / 1ps

package krt_pkg;

   localparam int MODE_W     = 2;
   localparam int STATUS_W   = 2;
   localparam int KEY_W      = 32;
   localparam int QTY_W      = 32;
   localparam int PRICE_W    = 32;
   localparam int SLOT_W     = 7;
   localparam int REQ_DATA_W = KEY_W + QTY_W + PRICE_W;
   localparam int RSP_FIELD_W = SLOT_W + QTY_W + PRICE_W;
   localparam int RSP_DATA_W = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - RSP_FIELD_W;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT    = 2'd0,
      MODE_LOOKUP    = 2'd1,
      MODE_ADJUST    = 2'd2,
      MODE_SET_PRICE = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_PRESENT   = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   // A request walking the cell chain. Once done is set, qty and price carry
   // the result values instead of the request operands.
   typedef struct packed {
      logic                valid;
      logic                done;
      logic                hit;
      mode_type            mode;
      status_type          status;
      logic [SLOT_W-1:0]   slot;
      logic [KEY_W-1:0]    key;
      logic [QTY_W-1:0]    qty;
      logic [PRICE_W-1:0]  price;
   } token_type;

endpackage

[hdl/keyed_record_table.sv]
`timescale 1ns / 1ps

// Channel   Dir   Ports                         Contents
// req       in    req_tvalid/tready/tdata/tuser  mode, key, quantity, price
// rsp       out   rsp_tvalid/tready/tdata/tuser  status, slot, quantity, price
//
// One request transaction is accepted per cycle while the chain advances.
// Each request walks all TABLE_DEPTH cells, one cell per cycle while the chain
// advances, and its response is then held in the output register. Reset
// clears the chain valid bits, the fill count and the output valid flag;
// record contents are not cleared. The whole chain holds while the
// response register is full, not taken, and the last cell holds a request.

module keyed_record_table #(
   parameter int TABLE_DEPTH = 128
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [31:0] part_key, [63:32] quantity_value, [95:64] price_value
   input  logic [krt_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [1:0] mode
   input  logic [krt_pkg::MODE_W-1:0]        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [6:0] slot_index, [38:7] quantity_out, [70:39] price_out, [71] zero
   output logic [krt_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // [1:0] status
   output logic [krt_pkg::STATUS_W-1:0]      rsp_tuser
);

   localparam int CountW = $clog2(TABLE_DEPTH + 1);

   // Token chain: entry g feeds cell g, entry TABLE_DEPTH leaves the last cell.
   krt_pkg::token_type            tok_chain [TABLE_DEPTH+1];
   krt_pkg::token_type            head_tok;
   logic [TABLE_DEPTH-1:0]        filled;
   logic [TABLE_DEPTH-1:0]        wr_vec;
   logic                          advance;
   logic                          load;
   logic [CountW-1:0]             fill_count_ff, fill_count_in;

   logic                          out_valid_ff, out_valid_in;
   krt_pkg::status_type           out_status_ff, out_status_in;
   logic [krt_pkg::SLOT_W-1:0]    out_slot_ff, out_slot_in;
   logic [krt_pkg::QTY_W-1:0]     out_qty_ff, out_qty_in;
   logic [krt_pkg::PRICE_W-1:0]   out_price_ff, out_price_in;

   // The chain moves unless a finished request at the tail has nowhere to go.
   assign advance    = !(out_valid_ff && !rsp_tready && tok_chain[TABLE_DEPTH].valid);
   assign req_tready = advance;
   assign load       = tok_chain[TABLE_DEPTH].valid && advance;

   always_comb begin
      head_tok       = '0;
      head_tok.valid = req_tvalid;
      head_tok.mode  = krt_pkg::mode_type'(req_tuser);
      head_tok.key   = req_tdata[31:0];
      head_tok.qty   = req_tdata[63:32];
      head_tok.price = req_tdata[95:64];
   end

   assign tok_chain[0] = head_tok;

   // Filled slots always form a prefix, so a slot is filled when its index
   // lies below the fill count.
   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      assign filled[g] = (fill_count_ff > CountW'(g));

      krt_cell #(
         .CELL_INDEX(g)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .filled  (filled[g]),
         .up_tok  (tok_chain[g]),
         .dn_tok  (tok_chain[g+1]),
         .wr_req  (wr_vec[g])
      );
   end

   // At most one cell writes a new record per cycle: the one at the fill count.
   always_comb begin
      fill_count_in = fill_count_ff;
      if (advance && (|wr_vec)) begin
         fill_count_in = fill_count_ff + CountW'(1);
      end
   end

   // A request that leaves the chain unresolved either found no free slot
   // (insert into a full table, duplicate or not) or never met its key.
   always_comb begin
      out_status_in = tok_chain[TABLE_DEPTH].status;
      out_slot_in   = tok_chain[TABLE_DEPTH].slot;
      out_qty_in    = tok_chain[TABLE_DEPTH].qty;
      out_price_in  = tok_chain[TABLE_DEPTH].price;
      if (!tok_chain[TABLE_DEPTH].done) begin
         if (tok_chain[TABLE_DEPTH].mode == krt_pkg::MODE_INSERT) begin
            out_status_in = krt_pkg::STATUS_FULL;
         end else begin
            out_status_in = krt_pkg::STATUS_NOT_FOUND;
         end
         out_slot_in  = '0;
         out_qty_in   = '0;
         out_price_in = '0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         fill_count_ff <= fill_count_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_status_ff <= out_status_in;
         out_slot_ff   <= out_slot_in;
         out_qty_ff    <= out_qty_in;
         out_price_ff  <= out_price_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{krt_pkg::RSP_PAD_W{1'b0}}, out_price_ff, out_qty_ff, out_slot_ff};
   assign rsp_tuser  = out_status_ff;

endmodule

[hdl/krt_cell.sv]
`timescale 1ns / 1ps

module krt_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                filled,
   input  krt_pkg::token_type  up_tok,
   output krt_pkg::token_type  dn_tok,
   output logic                wr_req
);

   localparam int SlotW   = krt_pkg::SLOT_W;
   localparam int SlotNum = CELL_INDEX % (2 ** SlotW);
   localparam logic [SlotW-1:0] SlotId = SlotW'(SlotNum);

   logic [krt_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [krt_pkg::QTY_W-1:0]   qty_ff, qty_in;
   logic [krt_pkg::PRICE_W-1:0] price_ff, price_in;
   krt_pkg::token_type          tok_ff, tok_in;
   logic                        valid_ff;
   logic                        match;

   always_comb begin
      tok_in   = up_tok;
      key_in   = key_ff;
      qty_in   = qty_ff;
      price_in = price_ff;
      wr_req   = 1'b0;
      match    = filled && (key_ff == up_tok.key);
      if (up_tok.valid && !up_tok.done) begin
         if (up_tok.mode == krt_pkg::MODE_INSERT) begin
            if (match) begin
               // Remember the duplicate; a full table still wins at the tail.
               tok_in.hit = 1'b1;
            end else if (!filled) begin
               tok_in.done = 1'b1;
               if (up_tok.hit) begin
                  tok_in.status = krt_pkg::STATUS_PRESENT;
                  tok_in.slot   = '0;
                  tok_in.qty    = '0;
                  tok_in.price  = '0;
               end else begin
                  wr_req        = 1'b1;
                  key_in        = up_tok.key;
                  qty_in        = up_tok.qty;
                  price_in      = up_tok.price;
                  tok_in.status = krt_pkg::STATUS_OK;
                  tok_in.slot   = SlotId;
               end
            end
         end else begin
            if (match) begin
               tok_in.done   = 1'b1;
               tok_in.status = krt_pkg::STATUS_OK;
               tok_in.slot   = SlotId;
               unique case (up_tok.mode)
                  krt_pkg::MODE_INSERT, krt_pkg::MODE_LOOKUP: begin
                     tok_in.qty   = qty_ff;
                     tok_in.price = price_ff;
                  end
                  krt_pkg::MODE_ADJUST: begin
                     qty_in       = qty_ff + up_tok.qty;
                     tok_in.qty   = qty_ff + up_tok.qty;
                     tok_in.price = price_ff;
                  end
                  krt_pkg::MODE_SET_PRICE: begin
                     price_in     = up_tok.price;
                     tok_in.qty   = qty_ff;
                  end
               endcase
            end else if (!filled) begin
               tok_in.done   = 1'b1;
               tok_in.status = krt_pkg::STATUS_NOT_FOUND;
               tok_in.slot   = '0;
               tok_in.qty    = '0;
               tok_in.price  = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= tok_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tok_ff   <= tok_in;
         key_ff   <= key_in;
         qty_ff   <= qty_in;
         price_ff <= price_in;
      end
   end

   always_comb begin
      dn_tok       = tok_ff;
      dn_tok.valid = valid_ff;
   end

endmodule

[hdl/krt_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module krt_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [krt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic [krt_pkg::STATUS_W-1:0]   rsp_tuser
);

   // A response that is waiting stays offered.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp dropped while stalled")

   // A response that is waiting does not change.
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && $stable(rsp_tuser), "rsp changed while stalled")

   // Any failed request reports zero slot, quantity and price.
   `ASSERT_IMPLY(a_fail_zero, clock, reset, rsp_tvalid && (rsp_tuser != krt_pkg::STATUS_OK), rsp_tdata == '0, "nonzero payload on failed request")

   // Reset leaves no response pending.
   `ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_tvalid, "response pending after reset")

endmodule

bind keyed_record_table krt_checker u_krt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

[tb/testbench.sv]
`timescale 1ns / 1ps

// Checks the keyed record table against a transaction-level copy of its table.
// Every accepted request is run through the copy at acceptance time, and the
// result it gives is queued. Responses come back in request order, so each
// one is compared with the oldest queued result.

module testbench;

   localparam int TABLE_DEPTH = 128;

   typedef struct {
      krt_pkg::mode_type mode;
      bit [31:0]         key;
      bit [31:0]         qty;
      bit [31:0]         price;
      int                gap;          // idle cycles before the request is offered
      bit                drain_first;  // hold the request until nothing is outstanding
   } request_type;

   typedef struct {
      krt_pkg::status_type status;
      bit [6:0]            slot;
      bit [31:0]           qty;
      bit [31:0]           price;
   } result_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   // [31:0] part_key, [63:32] quantity_value, [95:64] price_value
   logic [krt_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   // [1:0] mode
   logic [krt_pkg::MODE_W-1:0]     req_tuser = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   // [6:0] slot_index, [38:7] quantity_out, [70:39] price_out, [71] zero
   logic [krt_pkg::RSP_DATA_W-1:0] rsp_tdata;
   // [1:0] status
   logic [krt_pkg::STATUS_W-1:0]   rsp_tuser;

   keyed_record_table #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The table copy. Only slots below stored_count are ever searched.
   bit [31:0] stored_key   [TABLE_DEPTH];
   bit [31:0] stored_qty   [TABLE_DEPTH];
   bit [31:0] stored_price [TABLE_DEPTH];
   int        stored_count = 0;

   request_type pending_requests [$];
   result_type  awaited_results [$];

   // Keys the stimulus knows to be in the table, used to aim requests at hits.
   bit [31:0] known_keys [$];
   int        queued_count = 0;

   int        mismatches = 0;
   int        results_seen = 0;
   bit        hold_rsp = 1'b0;

   // Applies one request to the table copy and returns the response it owes.
   function automatic result_type apply_to_table(request_type r);
      result_type res;
      int         hit_slot;
      hit_slot = -1;
      for (int s = 0; s < stored_count; s++) begin
         if (hit_slot < 0 && stored_key[s] == r.key) hit_slot = s;
      end
      res.status = krt_pkg::STATUS_OK;
      res.slot   = '0;
      res.qty    = '0;
      res.price  = '0;
      if (r.mode == krt_pkg::MODE_INSERT) begin
         // A full table wins over a duplicate key.
         if (stored_count >= TABLE_DEPTH) begin
            res.status = krt_pkg::STATUS_FULL;
         end else if (hit_slot >= 0) begin
            res.status = krt_pkg::STATUS_PRESENT;
         end else begin
            hit_slot = stored_count;
            stored_key[hit_slot]   = r.key;
            stored_qty[hit_slot]   = r.qty;
            stored_price[hit_slot] = r.price;
            stored_count++;
         end
      end else if (hit_slot < 0) begin
         res.status = krt_pkg::STATUS_NOT_FOUND;
      end else if (r.mode == krt_pkg::MODE_ADJUST) begin
         stored_qty[hit_slot] = stored_qty[hit_slot] + r.qty;
      end else if (r.mode == krt_pkg::MODE_SET_PRICE) begin
         stored_price[hit_slot] = r.price;
      end
      if (res.status == krt_pkg::STATUS_OK) begin
         res.slot  = 7'(hit_slot);
         res.qty   = stored_qty[hit_slot];
         res.price = stored_price[hit_slot];
      end
      return res;
   endfunction

   // Mostly random words, with the boundary values mixed in often.
   function automatic bit [31:0] pick_value();
      bit [31:0] edges [6] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                               32'h0000_0000, 32'h0000_0001, 32'hAAAA_5555};
      if ($urandom_range(0, 4) == 0) return edges[$urandom_range(0, 5)];
      return $urandom();
   endfunction

   task automatic add_request(krt_pkg::mode_type mode, bit [31:0] key, bit [31:0] qty,
                              bit [31:0] price, bit drain_first);
      request_type r;
      bit          seen;
      r.mode        = mode;
      r.key         = key;
      r.qty         = qty;
      r.price       = price;
      r.drain_first = drain_first;
      // Every third stretch of 40 requests goes out back to back.
      r.gap = ((queued_count / 40) % 3 == 2) ? 0 : $urandom_range(0, 4);
      seen = 1'b0;
      foreach (known_keys[i]) if (known_keys[i] == key) seen = 1'b1;
      if (mode == krt_pkg::MODE_INSERT && !seen && known_keys.size() < TABLE_DEPTH)
         known_keys.push_back(key);
      pending_requests.push_back(r);
      queued_count++;
   endtask

   task automatic flag_error(string what);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $realtime, what);
   endtask

   // Request driver. A request is taken from the queue once the previous one
   // is accepted, waits out its gap, and is then held valid until accepted.
   request_type req_now;
   bit          req_have = 1'b0;
   bit          req_offer;
   int          req_wait = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid   <= 1'b0;
         req_have     = 1'b0;
         req_wait     = 0;
         req_now.mode = krt_pkg::MODE_INSERT;
      end else begin
         if (req_tvalid && req_tready) begin
            awaited_results.push_back(apply_to_table(req_now));
            req_have = 1'b0;
         end
         if (!req_have && pending_requests.size() > 0) begin
            if (!pending_requests[0].drain_first || awaited_results.size() == 0) begin
               req_now  = pending_requests.pop_front();
               req_have = 1'b1;
               req_wait = req_now.gap;
            end
         end
         req_offer = 1'b0;
         if (req_have) begin
            if (req_wait == 0) req_offer = 1'b1;
            else req_wait--;
         end
         req_tvalid <= req_offer;
         req_tuser  <= req_now.mode;
         req_tdata  <= {req_now.price, req_now.qty, req_now.key};
      end
   end

   // Response monitor. After each accepted response the receiver stalls for a
   // random number of cycles, except in every third stretch of 40 responses.
   result_type rsp_got;
   result_type rsp_want;
   int         rsp_stall = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall  = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_got.status = krt_pkg::status_type'(rsp_tuser);
            rsp_got.slot   = rsp_tdata[6:0];
            rsp_got.qty    = rsp_tdata[38:7];
            rsp_got.price  = rsp_tdata[70:39];
            if (awaited_results.size() == 0) begin
               flag_error($sformatf("response with nothing outstanding: status %s",
                                    rsp_got.status.name()));
            end else begin
               rsp_want = awaited_results.pop_front();
               if (rsp_got.status !== rsp_want.status || rsp_got.slot !== rsp_want.slot ||
                   rsp_got.qty !== rsp_want.qty || rsp_got.price !== rsp_want.price) begin
                  flag_error($sformatf({"expected %s slot %0d qty %h price %h, ",
                                        "got %s slot %0d qty %h price %h"},
                                       rsp_want.status.name(), rsp_want.slot, rsp_want.qty,
                                       rsp_want.price, rsp_got.status.name(), rsp_got.slot,
                                       rsp_got.qty, rsp_got.price));
               end
            end
            results_seen++;
            rsp_stall = ((results_seen / 40) % 3 == 1) ? 0 : $urandom_range(0, 4);
         end
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // One long back-pressure stretch. The sender keeps offering, so a request
   // reaches the tail of the cell chain and the block has to drop req_tready.
   initial begin
      wait (results_seen >= 60);
      @(negedge clock);
      hold_rsp = 1'b1;
      repeat (600) @(negedge clock);
      hold_rsp = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("keyed_record_table: mismatch");
      $finish;
   end

   initial begin
      krt_pkg::mode_type mode;
      bit [31:0]         key;
      int                pick;
      bit                fresh;

      // Directed requests on the empty table: misses first, then boundary
      // keys and values, a duplicate insert and quantity wraparound both ways.
      add_request(krt_pkg::MODE_LOOKUP,    32'h0000_0000, 32'h0, 32'h0, 1'b0);
      add_request(krt_pkg::MODE_ADJUST,    32'h0000_0005, 32'h1, 32'h0, 1'b0);
      add_request(krt_pkg::MODE_SET_PRICE, 32'h0000_0005, 32'h0, 32'h1, 1'b0);
      add_request(krt_pkg::MODE_INSERT,    32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  1'b0);
      add_request(krt_pkg::MODE_INSERT,    32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  1'b0);
      add_request(krt_pkg::MODE_INSERT,    32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                  1'b0);
      add_request(krt_pkg::MODE_INSERT,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  1'b0);
      add_request(krt_pkg::MODE_INSERT,    32'h8000_0000, 32'h1234_5678, 32'h1234_5678,
                  1'b0);
      add_request(krt_pkg::MODE_LOOKUP,    32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0);
      add_request(krt_pkg::MODE_ADJUST,    32'h8000_0000, 32'h0000_0001, 32'h0, 1'b0);
      add_request(krt_pkg::MODE_ADJUST,    32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0);
      add_request(krt_pkg::MODE_ADJUST,    32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0, 1'b0);
      add_request(krt_pkg::MODE_ADJUST,    32'h0000_0000, 32'hFFFF_FFFF, 32'h0, 1'b0);
      add_request(krt_pkg::MODE_SET_PRICE, 32'h0000_0000, 32'h0, 32'h8000_0000, 1'b0);
      add_request(krt_pkg::MODE_SET_PRICE, 32'hFFFF_FFFF, 32'h0, 32'h5555_AAAA, 1'b0);
      add_request(krt_pkg::MODE_LOOKUP,    32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0);
      add_request(krt_pkg::MODE_LOOKUP,    32'h1234_5678, 32'h0, 32'h0, 1'b0);
      add_request(krt_pkg::MODE_INSERT,    32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                  1'b0);
      add_request(krt_pkg::MODE_LOOKUP,    32'h0000_0000, 32'h0, 32'h0, 1'b0);
      add_request(krt_pkg::MODE_LOOKUP,    32'h8000_0000, 32'h0, 32'h0, 1'b0);

      // Random requests aimed mostly at keys already in the table. Inserts of
      // new keys fill the table part way through, so the later inserts run
      // into a full table, some of them with keys that are also present.
      for (int n = 0; n < 500; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40)      mode = krt_pkg::MODE_INSERT;
         else if (pick < 60) mode = krt_pkg::MODE_LOOKUP;
         else if (pick < 80) mode = krt_pkg::MODE_ADJUST;
         else                mode = krt_pkg::MODE_SET_PRICE;
         if (mode == krt_pkg::MODE_INSERT) fresh = ($urandom_range(0, 3) != 0);
         else                              fresh = ($urandom_range(0, 9) == 0);
         if (fresh || known_keys.size() == 0) key = pick_value();
         else key = known_keys[$urandom_range(0, known_keys.size() - 1)];
         add_request(mode, key, pick_value(), pick_value(), n == 0 || n == 250);
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock); while (pending_requests.size() > 0 || req_have);
      do @(negedge clock); while (awaited_results.size() > 0);
      // Leave room for any stray response still walking the chain.
      repeat (TABLE_DEPTH + 20) @(negedge clock);
      if (mismatches == 0) begin
         $display("keyed_record_table: match");
      end else begin
         $display("keyed_record_table: mismatch");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+hdl
hdl/krt_pkg.sv
hdl/krt_cell.sv
hdl/keyed_record_table.sv
hdl/krt_checker.sv
tb/testbench.sv
